[rtl/prs_pkg.sv]
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants of the prioritized replay sampler.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int DEPTH     = 1024;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = IDX_W + 1;
  localparam int PRIO_W    = 32;
  localparam int SUM_W     = PRIO_W + IDX_W;
  localparam int RUN_W     = SUM_W + 1;
  localparam int TAG_W     = 4;
  localparam int QUO_W     = 17;
  localparam int DIV_CNT_W = 5;

  localparam logic [PRIO_W-1:0]    PRIO_ONE  = 32'h0001_0000;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(QUO_W);

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_CAPACITY = 2'd1;
  localparam logic [1:0] REG_TASK     = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [1:0] STATUS_EMPTY     = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_UPDATE    = 2'd1,
    OP_SAMPLE    = 2'd2,
    OP_NORMALIZE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_SLOT,
    RD_IDX,
    RD_NORM
  } rd_sel_t;

  typedef enum logic [2:0] {
    RES_ADD,
    RES_UPDATE,
    RES_BAD_INDEX,
    RES_EMPTY,
    RES_SAMPLE,
    RES_NORMALIZE
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD,
    S_UPDATE,
    S_SUM,
    S_MUL,
    S_MUL2,
    S_SEARCH,
    S_FETCH,
    S_NRD,
    S_NLD,
    S_NDIV,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic      in_load;
    logic      wr_add;
    logic      wr_upd;
    logic      scan_start;
    logic      scan_search;
    logic      mul_go;
    logic      mul2_go;
    logic      hit_take;
    logic      norm_start;
    logic      div_start;
    logic      wr_norm;
    logic      out_load;
    rd_sel_t   rd_sel;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic idx_bad;
    logic n_zero;
    logic scan_done;
    logic weighted;
    logic div_busy;
    logic norm_last;
    logic out_free;
  } stat_t;

endpackage

[rtl/prs_div.sv]
// ----------------------------------------------------------------------------
// prs_div
// Restoring divider, one quotient bit per cycle: floor(p * 2^16 / d), p <= d.
// ----------------------------------------------------------------------------
module prs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [prs_pkg::PRIO_W-1:0]     dividend,
  input  logic [prs_pkg::SUM_W-1:0]      divisor,
  output logic                           busy,
  output logic [prs_pkg::QUO_W-1:0]      quotient
);

  logic [prs_pkg::DIV_CNT_W-1:0] cnt;
  logic [prs_pkg::RUN_W-1:0]     rem;
  logic [prs_pkg::SUM_W-1:0]     dsr;
  logic [prs_pkg::RUN_W-1:0]     trial;
  logic                          fits;

  // The first step compares without a shift, since the dividend may equal
  // the divisor and then the top quotient bit is set.
  always_comb begin
    if (cnt == prs_pkg::DIV_STEPS) begin
      trial = rem;
    end else begin
      trial = {rem[prs_pkg::RUN_W-2:0], 1'b0};
    end
    fits = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= prs_pkg::DIV_STEPS;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= prs_pkg::RUN_W'(dividend);
      dsr      <= divisor;
      quotient <= '0;
    end else if (cnt != '0) begin
      rem      <= fits ? trial - {1'b0, dsr} : trial;
      quotient <= {quotient[prs_pkg::QUO_W-2:0], fits};
    end
  end

  assign busy = cnt != '0;

endmodule

[rtl/prs_dp.sv]
// ----------------------------------------------------------------------------
// prs_dp
// Datapath: slot memories, ring pointers, scan engine, multipliers, divider
// and the output register.
// ----------------------------------------------------------------------------
module prs_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  prs_pkg::cmd_t               cmd,
  output prs_pkg::stat_t              stat,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [10:0]                 cfg_data,
  input  logic [1:0]                  op,
  input  logic [9:0]                  slot_index,
  input  logic signed [31:0]          update_priority,
  input  logic [31:0]                 random_fraction,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [9:0]                  slot,
  output logic [3:0]                  task_tag,
  output logic [31:0]                 priority_res,
  output logic [10:0]                 fill
);

  localparam int IW = prs_pkg::IDX_W;
  localparam int CW = prs_pkg::CNT_W;
  localparam int PW = prs_pkg::PRIO_W;
  localparam int SW = prs_pkg::SUM_W;
  localparam int RW = prs_pkg::RUN_W;
  localparam int TW = prs_pkg::TAG_W;

  // Configuration.
  logic          mode;
  logic [CW-1:0] capacity;
  logic [TW-1:0] cur_task;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= 1'b0;
      capacity <= CW'(prs_pkg::DEPTH);
      cur_task <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        prs_pkg::REG_MODE:     mode     <= cfg_data[0];
        prs_pkg::REG_CAPACITY: capacity <= cfg_data[CW-1:0];
        prs_pkg::REG_TASK:     cur_task <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Latched input item.
  prs_pkg::op_t  op_q;
  logic [IW-1:0] idx_q;
  logic [PW-1:0] prio_q;
  logic [31:0]   frac_q;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_q   <= prs_pkg::op_t'(op);
      idx_q  <= slot_index;
      prio_q <= update_priority[31] ? '0 : PW'(unsigned'(update_priority));
      frac_q <= random_fraction;
    end
  end

  // Ring pointers.
  logic [IW-1:0] head;
  logic [CW-1:0] fill_cnt;
  logic [CW-1:0] cap_eff;
  logic [IW-1:0] add_slot;
  logic [CW-1:0] head_inc;
  logic [IW-1:0] add_slot_q;
  logic [TW-1:0] add_tag_q;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (capacity > CW'(prs_pkg::DEPTH)) begin
      cap_eff = CW'(prs_pkg::DEPTH);
    end else begin
      cap_eff = capacity;
    end
    add_slot = ({1'b0, head} < cap_eff) ? head : '0;
    head_inc = {1'b0, add_slot} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      fill_cnt <= '0;
    end else if (cmd.wr_add) begin
      head <= (head_inc >= cap_eff) ? '0 : head_inc[IW-1:0];
      if (fill_cnt < cap_eff) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_add) begin
      add_slot_q <= add_slot;
      add_tag_q  <= cur_task;
    end
  end

  // Memories.
  logic [PW-1:0] prio_mem [prs_pkg::DEPTH];
  logic [TW-1:0] task_mem [prs_pkg::DEPTH];
  logic [PW-1:0] prio_rdata;
  logic [TW-1:0] task_rdata;
  logic [IW-1:0] rd_addr;
  logic          pw_en;
  logic [IW-1:0] pw_addr;
  logic [PW-1:0] pw_data;

  logic [CW-1:0] scan_addr;
  logic [IW-1:0] sel_slot;
  logic [CW-1:0] norm_idx;
  logic [prs_pkg::QUO_W-1:0] quotient;

  always_comb begin
    case (cmd.rd_sel)
      prs_pkg::RD_SCAN: rd_addr = scan_addr[IW-1:0];
      prs_pkg::RD_SLOT: rd_addr = sel_slot;
      prs_pkg::RD_IDX:  rd_addr = idx_q;
      prs_pkg::RD_NORM: rd_addr = norm_idx[IW-1:0];
      default:          rd_addr = scan_addr[IW-1:0];
    endcase
    pw_en = cmd.wr_add | cmd.wr_upd | cmd.wr_norm;
    if (cmd.wr_add) begin
      pw_addr = add_slot;
      pw_data = prs_pkg::PRIO_ONE;
    end else if (cmd.wr_upd) begin
      pw_addr = idx_q;
      pw_data = prio_q;
    end else begin
      pw_addr = norm_idx[IW-1:0];
      pw_data = PW'(quotient);
    end
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      prio_mem[pw_addr] <= pw_data;
    end
    prio_rdata <= prio_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_add) begin
      task_mem[add_slot] <= cur_task;
    end
    task_rdata <= task_mem[rd_addr];
  end

  // Scan engine: walks slots 0..fill-1 with one read in flight, summing or
  // searching for the first running sum that reaches the target.
  logic          scan_active;
  logic          scan_search;
  logic          rd_pending;
  logic [IW-1:0] rd_idx;
  logic [SW-1:0] sum;
  logic [RW-1:0] run;
  logic [RW-1:0] run_new;
  logic [RW-1:0] target;
  logic          found;
  logic [IW-1:0] hit;
  logic          scan_done;
  logic          issue;

  always_comb begin
    run_new   = run + RW'(prio_rdata);
    scan_done = scan_active & (found | ((scan_addr >= fill_cnt) & ~rd_pending));
    issue     = scan_active & ~scan_done & (scan_addr < fill_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      rd_pending  <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_active <= 1'b1;
      rd_pending  <= 1'b0;
    end else begin
      if (scan_done) begin
        scan_active <= 1'b0;
      end
      rd_pending <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr   <= '0;
      scan_search <= cmd.scan_search;
      found       <= 1'b0;
      hit         <= '0;
      run         <= '0;
      if (!cmd.scan_search) begin
        sum <= '0;
      end
    end else begin
      if (issue) begin
        scan_addr <= scan_addr + 1'b1;
        rd_idx    <= scan_addr[IW-1:0];
      end
      if (rd_pending && scan_active && !found) begin
        if (scan_search) begin
          run <= run_new;
          if (run_new >= target) begin
            found <= 1'b1;
            hit   <= rd_idx;
          end
        end else begin
          sum <= sum + SW'(prio_rdata);
        end
      end
    end
  end

  // Selection arithmetic.
  logic                      weighted;
  logic [63:0]               lo_prod;
  logic [SW-1:0]             hi_prod;
  logic [32+CW-1:0]          uni_prod;

  assign weighted = mode & (sum != '0);

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      lo_prod  <= frac_q * sum[31:0];
      hi_prod  <= SW'(frac_q) * SW'(sum[SW-1:32]);
      uni_prod <= frac_q * fill_cnt;
    end
    if (cmd.mul2_go) begin
      target   <= RW'(hi_prod) + RW'(lo_prod[63:32]);
      sel_slot <= uni_prod[32+IW-1:32];
    end else if (cmd.hit_take) begin
      sel_slot <= hit;
    end
  end

  // Normalization.
  logic div_busy;

  always_ff @(posedge clk) begin
    if (cmd.norm_start) begin
      norm_idx <= '0;
    end else if (cmd.wr_norm) begin
      norm_idx <= norm_idx + 1'b1;
    end
  end

  prs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ((sum != '0) ? prio_rdata : PW'(1)),
    .divisor  ((sum != '0) ? sum : SW'(fill_cnt)),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Output register.
  logic out_free;
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fill <= fill_cnt;
      case (cmd.res_kind)
        prs_pkg::RES_ADD: begin
          status       <= prs_pkg::STATUS_OK;
          slot         <= add_slot_q;
          task_tag     <= add_tag_q;
          priority_res <= prs_pkg::PRIO_ONE;
        end
        prs_pkg::RES_UPDATE: begin
          status       <= prs_pkg::STATUS_OK;
          slot         <= idx_q;
          task_tag     <= task_rdata;
          priority_res <= prio_q;
        end
        prs_pkg::RES_BAD_INDEX: begin
          status       <= prs_pkg::STATUS_BAD_INDEX;
          slot         <= idx_q;
          task_tag     <= '0;
          priority_res <= '0;
        end
        prs_pkg::RES_SAMPLE: begin
          status       <= prs_pkg::STATUS_OK;
          slot         <= sel_slot;
          task_tag     <= task_rdata;
          priority_res <= prio_rdata;
        end
        prs_pkg::RES_EMPTY: begin
          status       <= prs_pkg::STATUS_EMPTY;
          slot         <= '0;
          task_tag     <= '0;
          priority_res <= '0;
        end
        default: begin
          status       <= prs_pkg::STATUS_OK;
          slot         <= '0;
          task_tag     <= '0;
          priority_res <= '0;
        end
      endcase
    end
  end

  always_comb begin
    stat.op        = op_q;
    stat.idx_bad   = {1'b0, idx_q} >= fill_cnt;
    stat.n_zero    = fill_cnt == '0;
    stat.scan_done = scan_done;
    stat.weighted  = weighted;
    stat.div_busy  = div_busy;
    stat.norm_last = (norm_idx + 1'b1) == fill_cnt;
    stat.out_free  = out_free;
  end

endmodule

[rtl/prs_ctrl.sv]
// ----------------------------------------------------------------------------
// prs_ctrl
// Sequencer of the replay sampler: steps each item through its passes.
// ----------------------------------------------------------------------------
module prs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  prs_pkg::stat_t  stat,
  output prs_pkg::cmd_t   cmd,
  output logic            idle
);

  prs_pkg::state_t    state, state_next;
  prs_pkg::res_kind_t kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prs_pkg::S_IDLE;
      kind  <= prs_pkg::RES_EMPTY;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    cmd          = '0;
    cmd.rd_sel   = prs_pkg::RD_SCAN;
    cmd.res_kind = kind;
    idle         = 1'b0;
    case (state)
      prs_pkg::S_IDLE: begin
        idle        = 1'b1;
        cmd.in_load = accept;
        if (accept) begin
          state_next = prs_pkg::S_DISPATCH;
        end
      end
      prs_pkg::S_DISPATCH: begin
        case (stat.op)
          prs_pkg::OP_ADD: begin
            state_next = prs_pkg::S_ADD;
          end
          prs_pkg::OP_UPDATE: begin
            if (stat.idx_bad) begin
              kind_next  = prs_pkg::RES_BAD_INDEX;
              state_next = prs_pkg::S_RESULT;
            end else begin
              state_next = prs_pkg::S_UPDATE;
            end
          end
          default: begin
            if (stat.n_zero) begin
              kind_next  = prs_pkg::RES_EMPTY;
              state_next = prs_pkg::S_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = prs_pkg::S_SUM;
            end
          end
        endcase
      end
      prs_pkg::S_ADD: begin
        cmd.wr_add = 1'b1;
        kind_next  = prs_pkg::RES_ADD;
        state_next = prs_pkg::S_RESULT;
      end
      prs_pkg::S_UPDATE: begin
        cmd.wr_upd = 1'b1;
        cmd.rd_sel = prs_pkg::RD_IDX;
        kind_next  = prs_pkg::RES_UPDATE;
        state_next = prs_pkg::S_RESULT;
      end
      prs_pkg::S_SUM: begin
        if (stat.scan_done) begin
          if (stat.op == prs_pkg::OP_SAMPLE) begin
            state_next = prs_pkg::S_MUL;
          end else begin
            cmd.norm_start = 1'b1;
            state_next     = prs_pkg::S_NRD;
          end
        end
      end
      prs_pkg::S_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = prs_pkg::S_MUL2;
      end
      prs_pkg::S_MUL2: begin
        cmd.mul2_go = 1'b1;
        if (stat.weighted) begin
          cmd.scan_start  = 1'b1;
          cmd.scan_search = 1'b1;
          state_next      = prs_pkg::S_SEARCH;
        end else begin
          state_next = prs_pkg::S_FETCH;
        end
      end
      prs_pkg::S_SEARCH: begin
        if (stat.scan_done) begin
          cmd.hit_take = 1'b1;
          state_next   = prs_pkg::S_FETCH;
        end
      end
      prs_pkg::S_FETCH: begin
        cmd.rd_sel = prs_pkg::RD_SLOT;
        kind_next  = prs_pkg::RES_SAMPLE;
        state_next = prs_pkg::S_RESULT;
      end
      prs_pkg::S_NRD: begin
        cmd.rd_sel = prs_pkg::RD_NORM;
        state_next = prs_pkg::S_NLD;
      end
      prs_pkg::S_NLD: begin
        cmd.rd_sel    = prs_pkg::RD_NORM;
        cmd.div_start = 1'b1;
        state_next    = prs_pkg::S_NDIV;
      end
      prs_pkg::S_NDIV: begin
        if (!stat.div_busy) begin
          cmd.wr_norm = 1'b1;
          if (stat.norm_last) begin
            kind_next  = prs_pkg::RES_NORMALIZE;
            state_next = prs_pkg::S_RESULT;
          end else begin
            state_next = prs_pkg::S_NRD;
          end
        end
      end
      prs_pkg::S_RESULT: begin
        // Hold the read address so the registered read data stays put.
        if (kind == prs_pkg::RES_UPDATE) begin
          cmd.rd_sel = prs_pkg::RD_IDX;
        end else begin
          cmd.rd_sel = prs_pkg::RD_SLOT;
        end
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = prs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = prs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/prioritized_replay_sampler_unit.sv]
// ----------------------------------------------------------------------------
// prioritized_replay_sampler_unit
// Ring of 1024 replay slots with add, update, sample and normalize items.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the next is taken once the result sits in
// the output register. Sample runs the sum pass and, in weighted mode, the
// search pass over the single read port of the slot memory. Normalize runs
// the sum pass, then reads each slot and divides it by a bit-serial divider
// of 17 steps. No reset sweep is needed: slot contents are meaningful only
// once written.
module prioritized_replay_sampler_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic [9:0]           slot_index,
  input  logic signed [31:0]   update_priority,
  input  logic [31:0]          random_fraction,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [9:0]           slot,
  output logic [3:0]           task_tag,
  output logic [31:0]          priority_res,
  output logic [10:0]          fill
);

  prs_pkg::cmd_t  cmd;
  prs_pkg::stat_t stat;
  logic           idle;
  logic           accept;

  assign in_stall = ~idle;
  assign accept   = in_valid & idle;

  prs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .stat   (stat),
    .cmd    (cmd),
    .idle   (idle)
  );

  prs_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .op              (op),
    .slot_index      (slot_index),
    .update_priority (update_priority),
    .random_fraction (random_fraction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .slot            (slot),
    .task_tag        (task_tag),
    .priority_res    (priority_res),
    .fill            (fill)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("item accepted while previous item still in work");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting result");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider restarted while busy");

endmodule
